// File: rtl/mah_pkg.sv
`timescale 1ns / 1ps
// Shared types, reset constants and the class transition function for the
// moisture averaging block. No dependencies.
package mah_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int SPACING_W = 16;
	localparam int LEVEL_W   = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	localparam logic [SPACING_W-1:0] SPACING_RST      = 16'd1000;
	localparam logic [LEVEL_W-1:0]   WET_TO_MOIST_RST = 12'd1550;
	localparam logic [LEVEL_W-1:0]   MOIST_TO_DRY_RST = 12'd1700;
	localparam logic [LEVEL_W-1:0]   MOIST_TO_WET_RST = 12'd1500;
	localparam logic [LEVEL_W-1:0]   DRY_TO_MOIST_RST = 12'd1650;
	localparam logic [SAMPLE_W-1:0]  MIN_RST          = 12'd3000;

	typedef enum logic [1:0] {
		CLASS_WET   = 2'd0,
		CLASS_MOIST = 2'd1,
		CLASS_DRY   = 2'd2
	} moist_class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPACING      = 3'd0,
		REG_WET_TO_MOIST = 3'd1,
		REG_MOIST_TO_DRY = 3'd2,
		REG_MOIST_TO_WET = 3'd3,
		REG_DRY_TO_MOIST = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] wet_to_moist;
		logic [LEVEL_W-1:0] moist_to_dry;
		logic [LEVEL_W-1:0] moist_to_wet;
		logic [LEVEL_W-1:0] dry_to_moist;
	} levels_t;

	function automatic moist_class_t next_class(moist_class_t cls, logic [SAMPLE_W-1:0] mean,
			levels_t lv);
		moist_class_t nxt;
		nxt = cls;
		unique case (cls)
			CLASS_WET: begin
				if (mean > lv.wet_to_moist) nxt = CLASS_MOIST;
			end
			CLASS_MOIST: begin
				priority if (mean > lv.moist_to_dry) nxt = CLASS_DRY;
				else if (mean < lv.moist_to_wet) nxt = CLASS_WET;
				else nxt = CLASS_MOIST;
			end
			CLASS_DRY: begin
				if (mean < lv.dry_to_moist) nxt = CLASS_MOIST;
			end
			default: nxt = CLASS_WET;
		endcase
		return nxt;
	endfunction

endpackage

// File: rtl/mah_cell.sv
`timescale 1ns / 1ps
// One storage cell of the averaging window: holds a sample and passes it on
// to the next cell on each shift. Depends on mah_pkg.
module mah_cell import mah_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  logic [SAMPLE_W-1:0] din,
	output logic [SAMPLE_W-1:0] dout
);

	logic [SAMPLE_W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (shift) begin
			data_q <= din;
		end
	end

	assign dout = data_q;

endmodule

// File: rtl/mah_window.sv
`timescale 1ns / 1ps
// Averaging window: a chain of mah_cell instances and the running sum over
// them. Depends on mah_pkg and mah_cell.
module mah_window import mah_pkg::*; #(
	parameter int WINDOW_LENGTH = 40,
	parameter int SUM_W         = SAMPLE_W + $clog2(WINDOW_LENGTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  logic [SAMPLE_W-1:0] din,
	output logic [SUM_W-1:0]    sum
);

	logic [SAMPLE_W-1:0] tap [WINDOW_LENGTH+1];
	logic [SUM_W-1:0]    sum_q;

	assign tap[0] = din;

	for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
		mah_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.din    (tap[i]),
			.dout   (tap[i+1])
		);
	end

	// drop the oldest sample, add the new one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (shift) begin
			sum_q <= sum_q - SUM_W'(tap[WINDOW_LENGTH]) + SUM_W'(din);
		end
	end

	assign sum = sum_q;

endmodule

// File: rtl/moisture_average_hysteresis_core.sv
`timescale 1ns / 1ps
// Moisture averaging core: min/max tracking, decimated moving average over a
// shifting chain of cells, and a wet/moist/dry hysteresis classifier.
// Stages s1, s2, s3 are registered; one request per cycle unless stalled.
// The sum is divided by a constant multiply in the second stage.
// Reset clears all cells, the sum, the held mean and the class at once.
module moisture_average_hysteresis_core import mah_pkg::*; #(
	parameter int WINDOW_LENGTH = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic [SAMPLE_W-1:0]  raw_sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [SAMPLE_W-1:0]  mean_level,
	output logic [1:0]           moisture_class,
	output logic                 sample_taken,
	output logic [SAMPLE_W-1:0]  lowest_seen,
	output logic [SAMPLE_W-1:0]  highest_seen,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int LOG_N  = $clog2(WINDOW_LENGTH);
	localparam int SUM_W  = SAMPLE_W + LOG_N;
	localparam int SHIFT  = SUM_W + LOG_N;
	localparam int MUL_W  = SUM_W + 2;
	localparam int PROD_W = SUM_W + MUL_W;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
	localparam logic [MUL_W-1:0] RECIP_C = MUL_W'(RECIP);

	logic [SPACING_W-1:0] spacing_q;
	levels_t              levels_q;

	logic [SPACING_W-1:0] skip_q;
	logic [SAMPLE_W-1:0]  min_q, max_q, min_d, max_d;
	logic                 accept, take;
	logic [SUM_W-1:0]     sum;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 rdy1, rdy2, rdy3;
	logic                 taken_s1, taken_s2, taken_s3;
	logic [SAMPLE_W-1:0]  min_s1, min_s2, min_s3;
	logic [SAMPLE_W-1:0]  max_s1, max_s2, max_s3;
	logic [PROD_W-1:0]    prod_s2;
	logic [SAMPLE_W-1:0]  mean_q, mean_d;
	moist_class_t         class_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q             <= SPACING_RST;
			levels_q.wet_to_moist <= WET_TO_MOIST_RST;
			levels_q.moist_to_dry <= MOIST_TO_DRY_RST;
			levels_q.moist_to_wet <= MOIST_TO_WET_RST;
			levels_q.dry_to_moist <= DRY_TO_MOIST_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SPACING:      spacing_q             <= cfg_data;
				REG_WET_TO_MOIST: levels_q.wet_to_moist <= cfg_data[LEVEL_W-1:0];
				REG_MOIST_TO_DRY: levels_q.moist_to_dry <= cfg_data[LEVEL_W-1:0];
				REG_MOIST_TO_WET: levels_q.moist_to_wet <= cfg_data[LEVEL_W-1:0];
				REG_DRY_TO_MOIST: levels_q.dry_to_moist <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	assign rdy3         = !valid_s3 || !result_stall;
	assign rdy2         = !valid_s2 || rdy3;
	assign rdy1         = !valid_s1 || rdy2;
	assign sample_stall = !rdy1;
	assign accept       = sample_valid && rdy1;
	assign take         = skip_q >= spacing_q;

	// a new maximum blocks the minimum update on the same request
	always_comb begin
		max_d = max_q;
		min_d = min_q;
		priority if (max_q < raw_sample) max_d = raw_sample;
		else if (min_q > raw_sample) min_d = raw_sample;
		else max_d = max_q;
	end

	mah_window #(
		.WINDOW_LENGTH (WINDOW_LENGTH),
		.SUM_W         (SUM_W)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (accept && take),
		.din    (raw_sample),
		.sum    (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
			min_q  <= MIN_RST;
			max_q  <= '0;
		end else if (accept) begin
			skip_q <= take ? '0 : skip_q + SPACING_W'(1);
			min_q  <= min_d;
			max_q  <= max_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= sample_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			taken_s1 <= take;
			min_s1   <= min_d;
			max_s1   <= max_d;
		end
		if (rdy2 && valid_s1) begin
			taken_s2 <= taken_s1;
			min_s2   <= min_s1;
			max_s2   <= max_s1;
			prod_s2  <= PROD_W'(sum) * PROD_W'(RECIP_C);
		end
		if (rdy3 && valid_s2) begin
			taken_s3 <= taken_s2;
			min_s3   <= min_s2;
			max_s3   <= max_s2;
		end
	end

	assign mean_d = taken_s2 ? prod_s2[SHIFT +: SAMPLE_W] : mean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q  <= '0;
			class_q <= CLASS_WET;
		end else if (rdy3 && valid_s2) begin
			mean_q  <= mean_d;
			class_q <= next_class(class_q, mean_d, levels_q);
		end
	end

	assign result_valid   = valid_s3;
	assign mean_level     = mean_q;
	assign moisture_class = class_q;
	assign sample_taken   = taken_s3;
	assign lowest_seen    = min_s3;
	assign highest_seen   = max_s3;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && valid_s2 && valid_s3 && result_stall)
		else $error("input held back with a free stage");

	a_skip_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && take |=> skip_q == '0)
		else $error("skip count not cleared after a taken sample");

	a_class_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s2 && rdy3) |=> $stable(class_q) && $stable(mean_q))
		else $error("class or mean moved without a request");

endmodule
